[hdl/olwd_pkg.sv]
// Shared types and constants of the ordered list with delete by value.
package olwd_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] CMD_ADD_BACK  = 2'd0;
    localparam logic [1:0] CMD_ADD_FRONT = 2'd1;
    localparam logic [1:0] CMD_DELETE    = 2'd2;
    localparam logic [1:0] CMD_LIST      = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    localparam logic [2:0] CELL_HOLD      = 3'd0;
    localparam logic [2:0] CELL_ADD_BACK  = 3'd1;
    localparam logic [2:0] CELL_ADD_FRONT = 3'd2;
    localparam logic [2:0] CELL_DELETE    = 3'd3;
    localparam logic [2:0] CELL_ROTATE    = 3'd4;

    typedef struct packed {
        logic [2:0]       op;
        logic [31:0]      value;
        logic [CNT_W-1:0] count;
    } t_cell_ctrl;

endpackage

[hdl/olwd_cell.sv]
// One storage cell of the list chain, holding a single entry.
module olwd_cell (
    input  logic                           i_clk,
    input  logic [olwd_pkg::IDX_W-1:0]     i_index,
    input  olwd_pkg::t_cell_ctrl           i_ctrl,
    input  logic [31:0]                    i_left_data,
    input  logic [31:0]                    i_right_data,
    input  logic [31:0]                    i_head_data,
    input  logic                           i_found,
    output logic [31:0]                    o_data,
    output logic                           o_found
);

    logic [31:0]                r_data;
    logic [31:0]                n_data;
    logic [olwd_pkg::CNT_W-1:0] w_index;
    logic [olwd_pkg::CNT_W-1:0] w_last_index;
    logic                       w_in_range;

    assign w_index      = olwd_pkg::CNT_W'(i_index);
    assign w_last_index = i_ctrl.count - olwd_pkg::CNT_W'(1);
    assign w_in_range   = w_index < i_ctrl.count;
    assign o_found      = i_found | (w_in_range & (r_data == i_ctrl.value));
    assign o_data       = r_data;

    always_comb begin
        n_data = r_data;
        unique case (i_ctrl.op)
            olwd_pkg::CELL_HOLD: begin
                n_data = r_data;
            end
            olwd_pkg::CELL_ADD_BACK: begin
                if (w_index == i_ctrl.count) begin
                    n_data = i_ctrl.value;
                end
            end
            olwd_pkg::CELL_ADD_FRONT: begin
                if (w_index == '0) begin
                    n_data = i_ctrl.value;
                end else begin
                    n_data = i_left_data;
                end
            end
            olwd_pkg::CELL_DELETE: begin
                if (o_found) begin
                    n_data = i_right_data;
                end
            end
            olwd_pkg::CELL_ROTATE: begin
                if (w_index == w_last_index) begin
                    n_data = i_head_data;
                end else if (w_index < w_last_index) begin
                    n_data = i_right_data;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

[hdl/ordered_list_with_delete_by_value.sv]
// Top level of the ordered list with delete by value, built as a chain of cells.
// The list is held front to back in a row of cells, one entry per cell. Adding at the back,
// adding at the front and deleting the first match each give one result transfer; a delete
// compares the key in every cell at once and the cells from the match on take their right
// neighbour's entry. Listing rotates the chain by one cell per result transfer, emitting the
// front cell, so a listing of N values gives N transfers and leaves the order as it was. A
// new command is taken once the previous one has handed over its last result to the output
// register; while the output is held off, the input waits as well.
module ordered_list_with_delete_by_value (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // value[31:0]
    input  logic [1:0]  i_s_axis_tuser,   // cmd[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // item[31:0], occupancy[36:32], zero[39:37]
    output logic [1:0]  o_m_axis_tuser,   // status[1:0]
    output logic        o_m_axis_tlast
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_LIST = 1'b1;

    logic                       r_state;
    logic                       n_state;
    logic [olwd_pkg::CNT_W-1:0] r_count;
    logic [olwd_pkg::CNT_W-1:0] n_count;
    logic [olwd_pkg::CNT_W-1:0] r_list_idx;
    logic [olwd_pkg::CNT_W-1:0] n_list_idx;
    logic                       r_out_valid;
    logic                       n_out_valid;
    logic [31:0]                r_out_item;
    logic [31:0]                n_out_item;
    logic [1:0]                 r_out_status;
    logic [1:0]                 n_out_status;
    logic [olwd_pkg::CNT_W-1:0] r_out_occ;
    logic [olwd_pkg::CNT_W-1:0] n_out_occ;
    logic                       r_out_last;
    logic                       n_out_last;

    logic                       w_out_free;
    logic                       w_fire_in;
    logic                       w_full;
    logic                       w_list_last;
    olwd_pkg::t_cell_ctrl       w_ctrl;
    logic [31:0]                w_data  [olwd_pkg::DEPTH];
    logic                       w_found [olwd_pkg::DEPTH+1];

    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign w_fire_in       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_full          = r_count == olwd_pkg::CNT_W'(olwd_pkg::DEPTH);
    assign w_list_last     = r_list_idx == (r_count - olwd_pkg::CNT_W'(1));
    assign w_found[0]      = 1'b0;

    always_comb begin
        w_ctrl.value = i_s_axis_tdata;
        w_ctrl.count = r_count;
        w_ctrl.op    = olwd_pkg::CELL_HOLD;
        if (w_fire_in) begin
            unique case (i_s_axis_tuser)
                olwd_pkg::CMD_ADD_BACK: begin
                    w_ctrl.op = w_full ? olwd_pkg::CELL_HOLD : olwd_pkg::CELL_ADD_BACK;
                end
                olwd_pkg::CMD_ADD_FRONT: begin
                    w_ctrl.op = w_full ? olwd_pkg::CELL_HOLD : olwd_pkg::CELL_ADD_FRONT;
                end
                olwd_pkg::CMD_DELETE: begin
                    w_ctrl.op = olwd_pkg::CELL_DELETE;
                end
                default: begin
                    w_ctrl.op = olwd_pkg::CELL_HOLD;
                end
            endcase
        end else if ((r_state == S_LIST) && w_out_free) begin
            w_ctrl.op = olwd_pkg::CELL_ROTATE;
        end
    end

    for (genvar g = 0; g < olwd_pkg::DEPTH; g++) begin : g_cell
        logic [31:0] w_left;
        logic [31:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid
            assign w_left = w_data[g-1];
        end
        if (g == olwd_pkg::DEPTH - 1) begin : g_end
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_data[g+1];
        end
        olwd_cell u_cell (
            .i_clk        (i_clk),
            .i_index      (olwd_pkg::IDX_W'(g)),
            .i_ctrl       (w_ctrl),
            .i_left_data  (w_left),
            .i_right_data (w_right),
            .i_head_data  (w_data[0]),
            .i_found      (w_found[g]),
            .o_data       (w_data[g]),
            .o_found      (w_found[g+1])
        );
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_list_idx   = r_list_idx;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_item   = r_out_item;
        n_out_status = r_out_status;
        n_out_occ    = r_out_occ;
        n_out_last   = r_out_last;
        if (w_fire_in) begin
            n_out_valid  = 1'b1;
            n_out_item   = '0;
            n_out_status = olwd_pkg::ST_OK;
            n_out_last   = 1'b1;
            unique case (i_s_axis_tuser) inside
                olwd_pkg::CMD_ADD_BACK, olwd_pkg::CMD_ADD_FRONT: begin
                    if (w_full) begin
                        n_out_status = olwd_pkg::ST_FULL;
                    end else begin
                        n_count = r_count + olwd_pkg::CNT_W'(1);
                    end
                end
                olwd_pkg::CMD_DELETE: begin
                    if (w_found[olwd_pkg::DEPTH]) begin
                        n_count = r_count - olwd_pkg::CNT_W'(1);
                    end else begin
                        n_out_status = olwd_pkg::ST_NOT_FOUND;
                    end
                end
                default: begin
                    if (r_count == '0) begin
                        n_out_status = olwd_pkg::ST_EMPTY;
                    end else begin
                        n_out_valid = 1'b0;
                        n_state     = S_LIST;
                        n_list_idx  = '0;
                    end
                end
            endcase
            n_out_occ = n_count;
        end else if ((r_state == S_LIST) && w_out_free) begin
            n_out_valid  = 1'b1;
            n_out_item   = w_data[0];
            n_out_status = olwd_pkg::ST_OK;
            n_out_occ    = r_count;
            n_out_last   = w_list_last;
            n_list_idx   = r_list_idx + olwd_pkg::CNT_W'(1);
            if (w_list_last) begin
                n_state = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_list_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_list_idx  <= n_list_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item   <= n_out_item;
        r_out_status <= n_out_status;
        r_out_occ    <= n_out_occ;
        r_out_last   <= n_out_last;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, 5'(r_out_occ), r_out_item};
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tlast  = r_out_last;

endmodule
